### hdl/gct_pkg.sv
// Package for the generational capability table.
// Action, service and rights codes, the slot entry layout and small helpers.
// No dependencies.
package gct_pkg;

  localparam logic [3:0] A_OPEN_SVC  = 4'd0;
  localparam logic [3:0] A_OPEN_FILE = 4'd1;
  localparam logic [3:0] A_OPEN_IPC  = 4'd2;
  localparam logic [3:0] A_OPEN_SURF = 4'd3;
  localparam logic [3:0] A_GRANT     = 4'd4;
  localparam logic [3:0] A_RESOLVE   = 4'd5;
  localparam logic [3:0] A_CLOSE     = 4'd6;
  localparam logic [3:0] A_CLOSE_ALL = 4'd7;
  localparam logic [3:0] A_ASSIGN    = 4'd8;

  localparam logic [3:0] SVC_SURFACE = 4'd6;
  localparam logic [3:0] SVC_FILE    = 4'd8;
  localparam logic [3:0] SVC_IPC     = 4'd9;

  localparam logic [5:0] R_READ  = 6'h01;
  localparam logic [5:0] R_WRITE = 6'h02;
  localparam logic [5:0] R_QUERY = 6'h04;
  localparam logic [5:0] R_OPEN  = 6'h08;
  localparam logic [5:0] R_SEND  = 6'h10;
  localparam logic [5:0] R_RECV  = 6'h20;

  localparam int MAX_RESULTS = 8;
  localparam int KW          = $clog2(MAX_RESULTS);
  localparam int RCW         = KW + 1;

  typedef struct packed {
    logic        open;
    logic [3:0]  service;
    logic [5:0]  rights;
    logic [15:0] generation;
    logic [31:0] object;
  } slot_t;

  function automatic logic [5:0] fixed_rights(input logic [3:0] s);
    logic [5:0] r;
    unique case (s)
      4'd0:        r = R_WRITE;
      4'd1, 4'd2:  r = R_QUERY;
      4'd3, 4'd6:  r = R_OPEN | R_QUERY;
      4'd4:        r = R_WRITE | R_QUERY;
      4'd5, 4'd7:  r = R_READ | R_QUERY;
      default:     r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, c} + {31'd0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Close: drop rights and object, bump generation skipping zero.
  function automatic slot_t shut(input slot_t e);
    slot_t r;
    r = e;
    r.open = 1'b0;
    r.rights = 6'd0;
    r.object = 32'd0;
    r.generation = (e.generation == 16'hFFFF) ? 16'd1 : e.generation + 16'd1;
    return r;
  endfunction

endpackage

### hdl/gct_if.sv
// Request and response channel interfaces of the capability table.
// Valid/ready handshake with the payload fields; no dependencies.
interface gct_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [2:0]  pid;
  logic [3:0]  service;
  logic [31:0] obj_num;
  logic [5:0]  rights;
  logic [63:0] handle;
  logic [2:0]  dest_pid;
  logic [5:0]  need_rights;
  logic        surface_ok;
  logic [9:0]  svc_mask;

  modport source(output valid, action, pid, service, obj_num, rights, handle,
                 dest_pid, need_rights, surface_ok, svc_mask, input ready);
  modport sink(input valid, action, pid, service, obj_num, rights, handle,
               dest_pid, need_rights, surface_ok, svc_mask, output ready);
endinterface

interface gct_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] handle_out;
  logic [3:0]  service_out;
  logic [31:0] object_out;
  logic        release_surface;
  logic [31:0] release_object;
  logic        last;
  logic [31:0] opened_total;
  logic [31:0] closed_total;
  logic [31:0] denied_total;
  logic [6:0]  live_total;

  modport source(output valid, ok, handle_out, service_out, object_out, release_surface,
                 release_object, last, opened_total, closed_total, denied_total,
                 live_total, input ready);
  modport sink(input valid, ok, handle_out, service_out, object_out, release_surface,
               release_object, last, opened_total, closed_total, denied_total,
               live_total, output ready);
endinterface

### hdl/gct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/generational_capability_table_core.sv
// Generational capability table: per-process slot table in RAM, sequencer.
// Depends on gct_pkg, gct_if (gct_req_if, gct_rsp_if) and gct_ram.
//
//  channel | dir | transactions
//  req     | in  | one request per transaction
//  rsp     | out | 1..MAX_RESULTS results per request, last marks the final one
//
// Resolve, close, assign, denials: result registered in EMIT after EVAL, next request
// accepted once EMIT has handed it over and the sequencer is back in IDLE.
// Opens and grants that pass scan the new owner's slots (grants: the target's),
// SCAN_RD, SCAN_CHK per slot (1 RAM port). Close all: CA_RD, CA_CHK per slot,
// then EMIT per result. After reset a clearing pass over every slot address
// initializes both RAMs; req.ready stays low meanwhile.
// A stalled rsp holds the sequencer only while it has a result to hand over.
module generational_capability_table_core
  import gct_pkg::*;
#(
  parameter int PROCESSES = 8,
  parameter int SLOTS     = 8
) (
  input logic    clk,
  input logic    rst,
  gct_req_if.sink   req,
  gct_rsp_if.source rsp
);
  localparam int PW    = $clog2(PROCESSES);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW    = PW + SW;
  localparam int DEPTH = 1 << AW;
  localparam int LW    = $clog2(PROCESSES * SLOTS + 1);
  localparam int SLOT_W = $bits(slot_t);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_EVAL     = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_CA_RD    = 4'd5;
  localparam logic [3:0] S_CA_CHK   = 4'd6;
  localparam logic [3:0] S_EMIT     = 4'd7;

  logic [3:0]    state;
  logic [AW-1:0] clr_cnt;

  logic [3:0]  r_action;
  logic [2:0]  r_pid;
  logic [3:0]  r_service;
  logic [31:0] r_object;
  logic [5:0]  r_rights;
  logic [63:0] r_handle;
  logic [2:0]  r_target;
  logic [5:0]  r_required;
  logic        r_sok;
  logic [9:0]  r_mask;

  logic [PW-1:0] owner;
  logic [SW-1:0] s_idx;
  logic [3:0]    n_svc;
  logic [5:0]    n_rights;
  logic [31:0]   n_obj;
  logic          rel_full;

  logic        res_ok;
  logic [31:0] res_handle;
  logic [3:0]  res_service;
  logic [31:0] res_object;
  logic [31:0] rel_buf [MAX_RESULTS];
  logic [RCW-1:0] rel_cnt;
  logic [KW-1:0]  emit_k;

  logic [31:0]   opened;
  logic [31:0]   closed;
  logic [31:0]   denied;
  logic [LW-1:0] live;

  logic              slot_we;
  logic [AW-1:0]     slot_waddr;
  slot_t             slot_wdata;
  logic [AW-1:0]     slot_raddr;
  logic [SLOT_W-1:0] slot_rdata;
  slot_t             rd;

  logic          alloc_we;
  logic [PW-1:0] alloc_waddr;
  logic [9:0]    alloc_wdata;
  logic [PW-1:0] alloc_raddr;
  logic [9:0]    msk;

  logic        pid_ok, tgt_ok, fmt_ok, lk_ok, svc_bit, surf_bit, ipc_bit;
  logic [7:0]  hp, hs;
  logic [15:0] hg;
  logic [5:0]  req_bits, fr;
  logic        is_open, open_pre;
  logic [1:0]  deny_n;
  logic [PW-1:0] open_owner;
  logic [3:0]  open_svc;
  logic [5:0]  open_rights;
  logic [31:0] open_obj;
  logic        open_rel;
  logic        last_slot, emit_last, rd_rel;

  gct_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  gct_ram #(.WIDTH(10), .DEPTH(PROCESSES)) u_alloc (
    .clk(clk), .we(alloc_we), .waddr(alloc_waddr), .wdata(alloc_wdata),
    .raddr(alloc_raddr), .rdata(msk)
  );

  assign rd = slot_t'(slot_rdata);
  assign req.ready = (state == S_IDLE);

  assign slot_raddr = (state == S_IDLE) ? {PW'(req.handle[15:8]), SW'(req.handle[7:0])}
                                        : {owner, s_idx};
  assign alloc_raddr = PW'((req.action == A_GRANT) ? req.dest_pid : req.pid);

  assign hp = r_handle[15:8];
  assign hs = r_handle[7:0];
  assign hg = r_handle[31:16];
  assign pid_ok = (r_pid != 3'd0) && (32'(r_pid) < PROCESSES);
  assign tgt_ok = (r_target != 3'd0) && (32'(r_target) < PROCESSES);
  assign fmt_ok = (r_handle[63:32] == 32'd0) && (32'(hp) < PROCESSES) &&
                  (32'(hs) < SLOTS) && (hg != 16'd0) && (hp == 8'(r_pid));
  assign req_bits = (r_action == A_GRANT) ? r_rights :
                    (r_action == A_RESOLVE) ? r_required : 6'd0;
  assign lk_ok = fmt_ok && rd.open && (rd.generation == hg) &&
                 ((rd.rights & req_bits) == req_bits);
  assign svc_bit  = |(msk & (10'd1 << r_service));
  assign surf_bit = msk[SVC_SURFACE];
  assign ipc_bit  = msk[SVC_IPC];
  assign fr = fixed_rights(r_service);
  assign last_slot = (s_idx == SW'(SLOTS - 1));
  assign rd_rel = (rd.service == SVC_SURFACE) && (rd.object != 32'd0);
  assign emit_last = ({1'b0, emit_k} + RCW'(1)) >= rel_cnt;

  always_comb begin
    is_open = 1'b1;
    open_pre = 1'b0;
    deny_n = 2'd1;
    open_owner = PW'(r_pid);
    open_svc = r_service;
    open_rights = fr;
    open_obj = 32'd0;
    open_rel = 1'b0;
    unique case (r_action)
      A_OPEN_SVC: open_pre = pid_ok && (fr != 6'd0) && svc_bit;
      A_OPEN_FILE: begin
        open_pre = pid_ok && (r_object != 32'd0);
        open_svc = SVC_FILE;
        open_rights = R_READ | R_WRITE | R_QUERY;
        open_obj = r_object;
      end
      A_OPEN_IPC: begin
        open_pre = pid_ok && (r_object != 32'd0) && (r_rights != 6'd0) &&
                   ((r_rights & ~(R_SEND | R_RECV | R_QUERY)) == 6'd0) && ipc_bit;
        open_svc = SVC_IPC;
        open_rights = r_rights;
        open_obj = r_object;
      end
      A_OPEN_SURF: begin
        open_pre = pid_ok && (r_object != 32'd0) && (r_rights != 6'd0) &&
                   ((r_rights & ~(R_READ | R_WRITE | R_QUERY)) == 6'd0) &&
                   surf_bit && r_sok;
        open_svc = SVC_SURFACE;
        open_rights = r_rights;
        open_obj = r_object;
        open_rel = 1'b1;
      end
      A_GRANT: begin
        open_pre = tgt_ok && (r_rights != 6'd0) && lk_ok && (rd.service == SVC_SURFACE) &&
                   ((r_rights & ~(R_READ | R_QUERY)) == 6'd0) && surf_bit && r_sok;
        deny_n = (tgt_ok && (r_rights != 6'd0) && !lk_ok) ? 2'd2 : 2'd1;
        open_owner = PW'(r_target);
        open_svc = SVC_SURFACE;
        open_rights = r_rights;
        open_obj = rd.object;
        open_rel = 1'b1;
      end
      default: is_open = 1'b0;
    endcase
  end

  always_comb begin
    slot_we = 1'b0;
    slot_waddr = {owner, s_idx};
    slot_wdata = rd;
    alloc_we = 1'b0;
    alloc_waddr = PW'(r_pid);
    alloc_wdata = 10'd0;
    unique case (state)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_waddr = clr_cnt;
        slot_wdata = '0;
        slot_wdata.generation = 16'd1;
        alloc_we = (clr_cnt < AW'(PROCESSES));
        alloc_waddr = PW'(clr_cnt);
        alloc_wdata = ((clr_cnt == AW'(1)) || (clr_cnt == AW'(2))) ? 10'h3FF : 10'd0;
      end
      S_EVAL: begin
        slot_we = (r_action == A_CLOSE) && lk_ok;
        slot_wdata = shut(rd);
        alloc_we = pid_ok && ((r_action == A_ASSIGN) || (r_action == A_CLOSE_ALL));
        alloc_wdata = (r_action == A_ASSIGN) ? r_mask : 10'd0;
      end
      S_SCAN_CHK: begin
        slot_we = !rd.open;
        slot_wdata.open = 1'b1;
        slot_wdata.service = n_svc;
        slot_wdata.rights = n_rights;
        slot_wdata.object = n_obj;
      end
      S_CA_CHK: begin
        slot_we = rd.open;
        slot_wdata = shut(rd);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      opened <= 32'd0;
      closed <= 32'd0;
      denied <= 32'd0;
      live <= '0;
      rel_cnt <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_EMIT)) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (&clr_cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            r_action <= req.action;
            r_pid <= req.pid;
            r_service <= req.service;
            r_object <= req.obj_num;
            r_rights <= req.rights;
            r_handle <= req.handle;
            r_target <= req.dest_pid;
            r_required <= req.need_rights;
            r_sok <= req.surface_ok;
            r_mask <= req.svc_mask;
            owner <= PW'(req.handle[15:8]);
            s_idx <= SW'(req.handle[7:0]);
            res_ok <= 1'b0;
            res_handle <= 32'd0;
            res_service <= 4'd0;
            res_object <= 32'd0;
            rel_cnt <= '0;
            emit_k <= '0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_EMIT;
          if (is_open) begin
            if (open_pre) begin
              owner <= open_owner;
              s_idx <= '0;
              n_svc <= open_svc;
              n_rights <= open_rights;
              n_obj <= open_obj;
              rel_full <= open_rel;
              state <= S_SCAN_RD;
            end else begin
              denied <= sat_add(denied, deny_n);
            end
          end else begin
            unique case (r_action)
              A_RESOLVE: begin
                if (lk_ok) begin
                  res_ok <= 1'b1;
                  res_service <= rd.service;
                  res_object <= rd.object;
                end else begin
                  denied <= sat_add(denied, 2'd1);
                end
              end
              A_CLOSE: begin
                if (lk_ok) begin
                  res_ok <= 1'b1;
                  closed <= sat_add(closed, 2'd1);
                  live <= live - LW'(1);
                  if (rd_rel) begin
                    rel_buf[0] <= rd.object;
                    rel_cnt <= RCW'(1);
                  end
                end else begin
                  denied <= sat_add(denied, 2'd1);
                end
              end
              A_CLOSE_ALL: begin
                res_ok <= pid_ok;
                if (pid_ok) begin
                  owner <= PW'(r_pid);
                  s_idx <= '0;
                  state <= S_CA_RD;
                end
              end
              A_ASSIGN: res_ok <= pid_ok;
              default: ;
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (!rd.open) begin
            opened <= sat_add(opened, 2'd1);
            live <= live + LW'(1);
            res_ok <= 1'b1;
            res_handle <= {rd.generation, 8'(owner), 8'(s_idx)};
            state <= S_EMIT;
          end else if (last_slot) begin
            denied <= sat_add(denied, 2'd1);
            if (rel_full) begin
              rel_buf[0] <= n_obj;
              rel_cnt <= RCW'(1);
            end
            state <= S_EMIT;
          end else begin
            s_idx <= s_idx + SW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_CA_RD: state <= S_CA_CHK;
        S_CA_CHK: begin
          if (rd.open) begin
            closed <= sat_add(closed, 2'd1);
            live <= live - LW'(1);
            if (rd_rel && (rel_cnt < RCW'(MAX_RESULTS))) begin
              rel_buf[rel_cnt[KW-1:0]] <= rd.object;
              rel_cnt <= rel_cnt + RCW'(1);
            end
          end
          if (last_slot) begin
            state <= S_EMIT;
          end else begin
            s_idx <= s_idx + SW'(1);
            state <= S_CA_RD;
          end
        end
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.ok <= res_ok;
            rsp.handle_out <= res_handle;
            rsp.service_out <= res_service;
            rsp.object_out <= res_object;
            rsp.release_surface <= ({1'b0, emit_k} < rel_cnt);
            rsp.release_object <= ({1'b0, emit_k} < rel_cnt) ? rel_buf[emit_k] : 32'd0;
            rsp.last <= emit_last;
            rsp.opened_total <= opened;
            rsp.closed_total <= closed;
            rsp.denied_total <= denied;
            rsp.live_total <= (32'(live) > 127) ? 7'd127 : 7'(live);
            emit_k <= emit_k + KW'(1);
            if (emit_last) state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !rsp.valid) else $error("response during clearing pass");
  a_rel_bound: assert property (@(posedge clk) disable iff (rst)
    rel_cnt <= RCW'(MAX_RESULTS)) else $error("release count overflow");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live) <= PROCESSES * SLOTS) else $error("live count out of range");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !slot_we && !alloc_we) else $error("RAM write while idle");
`endif
endmodule

### tb/gct_tb_if.sv
// Scoreboard package for the capability table testbench: result type and predictor.
// Depends on gct_pkg.
package gct_tb_pkg;
  import gct_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [31:0] handle_out;
    logic [3:0]  service_out;
    logic [31:0] object_out;
    logic        release_surface;
    logic [31:0] release_object;
    logic        last;
    logic [31:0] opened_total;
    logic [31:0] closed_total;
    logic [31:0] denied_total;
    logic [6:0]  live_total;
  } cap_result_t;

  class cap_table_board;
    logic        open_q[8][8];
    logic [3:0]  svc_q[8][8];
    logic [5:0]  rights_q[8][8];
    logic [15:0] gen_q[8][8];
    logic [31:0] obj_q[8][8];
    logic [9:0]  allowed[8];
    logic [31:0] opened, closed, denied;
    cap_result_t pending[$];
    int          errors;

    function new();
      for (int p = 0; p < 8; p++) begin
        for (int s = 0; s < 8; s++) begin
          open_q[p][s] = 0; svc_q[p][s] = 0; rights_q[p][s] = 0;
          gen_q[p][s] = 16'd1; obj_q[p][s] = 0;
        end
        allowed[p] = (p == 1 || p == 2) ? 10'h3FF : 10'h0;
      end
      opened = 0; closed = 0; denied = 0; errors = 0;
    endfunction

    function void bump(ref logic [31:0] c);
      if (c != 32'hFFFF_FFFF) c = c + 32'd1;
    endfunction

    function bit svc_ok(int p, logic [3:0] s);
      return s < 10 && allowed[p][s];
    endfunction

    function logic [5:0] svc_rights(logic [3:0] s);
      case (s)
        4'd0: return R_WRITE;
        4'd1, 4'd2: return R_QUERY;
        4'd3, 4'd6: return R_OPEN | R_QUERY;
        4'd4: return R_WRITE | R_QUERY;
        4'd5, 4'd7: return R_READ | R_QUERY;
        default: return 6'd0;
      endcase
    endfunction

    function bit claim(int p, logic [3:0] sv, logic [5:0] r, logic [31:0] o,
                       output logic [31:0] h);
      h = 0;
      for (int s = 0; s < 8; s++) begin
        if (!open_q[p][s]) begin
          open_q[p][s] = 1; svc_q[p][s] = sv; rights_q[p][s] = r; obj_q[p][s] = o;
          bump(opened);
          h = {gen_q[p][s], 5'd0, p[2:0], 5'd0, s[2:0]};
          return 1;
        end
      end
      bump(denied);
      return 0;
    endfunction

    function bit find(int caller, logic [63:0] h, logic [5:0] need,
                      output int p, output int s);
      s = int'(h[7:0]); p = int'(h[15:8]);
      if (h[63:32] != 0 || p >= 8 || s >= 8 || h[31:16] == 0 || p != caller) begin
        bump(denied); return 0;
      end
      if (!open_q[p][s] || gen_q[p][s] != h[31:16] || (rights_q[p][s] & need) != need) begin
        bump(denied); return 0;
      end
      return 1;
    endfunction

    function logic [31:0] shut_slot(int p, int s);
      logic [31:0] o;
      o = (svc_q[p][s] == SVC_SURFACE) ? obj_q[p][s] : 32'd0;
      open_q[p][s] = 0; rights_q[p][s] = 0; obj_q[p][s] = 0;
      gen_q[p][s] = (gen_q[p][s] == 16'hFFFF) ? 16'd1 : gen_q[p][s] + 16'd1;
      bump(closed);
      return o;
    endfunction

    function void note_request(logic [3:0] act, logic [2:0] pid, logic [3:0] sv,
                               logic [31:0] obj, logic [5:0] r, logic [63:0] hd,
                               logic [2:0] tgt, logic [5:0] need, logic sok,
                               logic [9:0] mask);
      cap_result_t res[8];
      int n, p, s, rn, live;
      bit ok, pid_ok, pass;
      logic [31:0] h, ro;
      n = 1; ok = 0; h = 0; pid_ok = pid != 0;
      for (int k = 0; k < 8; k++) res[k] = '0;
      case (act)
        A_OPEN_SVC:
          if (!pid_ok || svc_rights(sv) == 0 || !svc_ok(pid, sv)) bump(denied);
          else ok = claim(pid, sv, svc_rights(sv), 0, h);
        A_OPEN_FILE:
          if (!pid_ok || obj == 0) bump(denied);
          else ok = claim(pid, SVC_FILE, R_READ | R_WRITE | R_QUERY, obj, h);
        A_OPEN_IPC:
          if (!pid_ok || obj == 0 || r == 0 || (r & ~(R_SEND | R_RECV | R_QUERY)) != 0 ||
              !svc_ok(pid, SVC_IPC)) bump(denied);
          else ok = claim(pid, SVC_IPC, r, obj, h);
        A_OPEN_SURF:
          if (!pid_ok || obj == 0 || r == 0 || (r & ~(R_READ | R_WRITE | R_QUERY)) != 0 ||
              !svc_ok(pid, SVC_SURFACE) || !sok) bump(denied);
          else begin
            ok = claim(pid, SVC_SURFACE, r, obj, h);
            if (!ok) begin res[0].release_surface = 1; res[0].release_object = obj; end
          end
        A_GRANT: begin
          pass = tgt != 0 && r != 0;
          if (pass) pass = find(pid, hd, r, p, s);
          if (pass) pass = svc_q[p][s] == SVC_SURFACE && (r & ~(R_READ | R_QUERY)) == 0 &&
                           svc_ok(tgt, SVC_SURFACE) && sok;
          if (!pass) bump(denied);
          else begin
            ro = obj_q[p][s];
            ok = claim(tgt, SVC_SURFACE, r, ro, h);
            if (!ok) begin res[0].release_surface = 1; res[0].release_object = ro; end
          end
        end
        A_RESOLVE:
          if (find(pid, hd, need, p, s)) begin
            ok = 1; res[0].service_out = svc_q[p][s]; res[0].object_out = obj_q[p][s];
          end
        A_CLOSE:
          if (find(pid, hd, 6'd0, p, s)) begin
            ro = shut_slot(p, s); ok = 1;
            if (ro != 0) begin res[0].release_surface = 1; res[0].release_object = ro; end
          end
        A_CLOSE_ALL:
          if (pid_ok) begin
            rn = 0; ok = 1;
            for (int i = 0; i < 8; i++) begin
              if (open_q[pid][i]) begin
                ro = shut_slot(pid, i);
                if (ro != 0 && rn < 8) begin
                  res[rn].release_surface = 1; res[rn].release_object = ro; rn++;
                end
              end
            end
            allowed[pid] = 0;
            if (rn > 0) n = rn;
          end
        A_ASSIGN:
          if (pid_ok) begin allowed[pid] = mask; ok = 1; end
        default: ;
      endcase
      if (ok) res[0].handle_out = h;
      live = 0;
      for (int pp = 1; pp < 8; pp++)
        for (int ss = 0; ss < 8; ss++) live += open_q[pp][ss];
      for (int k = 0; k < n; k++) begin
        res[k].ok = ok; res[k].last = (k == n - 1);
        res[k].opened_total = opened; res[k].closed_total = closed;
        res[k].denied_total = denied; res[k].live_total = 7'(live);
        pending.push_back(res[k]);
      end
    endfunction

    function void check_result(cap_result_t got);
      cap_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass
endpackage

### tb/generational_capability_table_core_tb.sv
// Testbench top for generational_capability_table_core.
// Depends on gct_pkg, gct_if, gct_tb_pkg (scoreboard) and the core RTL.
module generational_capability_table_core_tb;
  import gct_pkg::*;
  import gct_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  gct_req_if req();
  gct_rsp_if rsp();

  generational_capability_table_core i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  cap_table_board board = new();
  bit          quiet = 0;
  int          idle_cycles = 0;
  logic [63:0] known_handles[$];

  initial begin
    req.valid = 0; req.action = 0; req.pid = 0; req.service = 0; req.obj_num = 0;
    req.rights = 0; req.handle = 0; req.dest_pid = 0; req.need_rights = 0;
    req.surface_ok = 0; req.svc_mask = 0; rsp.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      board.note_request(req.action, req.pid, req.service, req.obj_num, req.rights,
                         req.handle, req.dest_pid, req.need_rights, req.surface_ok,
                         req.svc_mask);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (rsp.ok && rsp.handle_out != 0) known_handles.push_back({32'd0, rsp.handle_out});
      if (known_handles.size() > 40) void'(known_handles.pop_front());
      board.check_result({rsp.ok, rsp.handle_out, rsp.service_out, rsp.object_out,
                          rsp.release_surface, rsp.release_object, rsp.last,
                          rsp.opened_total, rsp.closed_total, rsp.denied_total,
                          rsp.live_total});
    end
  end

  // Watchdog on acceptance activity.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("generational_capability_table_core_tb failed");
      $finish;
    end
  end

  // Response side stalls.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        rsp.ready <= 0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
    end
  end

  task automatic send(logic [3:0] act, logic [2:0] pid, logic [3:0] sv, logic [31:0] obj,
                      logic [5:0] r, logic [63:0] hd, logic [2:0] tgt, logic [5:0] need,
                      logic sok, logic [9:0] mask);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      req.valid <= 0;
      repeat (n) @(posedge clk);
    end
    req.valid <= 1; req.action <= act; req.pid <= pid; req.service <= sv;
    req.obj_num <= obj; req.rights <= r; req.handle <= hd; req.dest_pid <= tgt;
    req.need_rights <= need; req.surface_ok <= sok; req.svc_mask <= mask;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic [63:0] pick_handle();
    logic [63:0] h;
    case ($urandom_range(0, 9))
      0: h = {$urandom, $urandom};
      1: h = {32'd0, 16'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      2: h = {32'd0, $urandom};
      default:
        if (known_handles.size() > 0) h = known_handles[$urandom_range(0, known_handles.size() - 1)];
        else h = {32'd0, 16'd1, 8'd1, 8'd0};
    endcase
    return h;
  endfunction

  task automatic random_item();
    logic [3:0] act;
    logic [2:0] pid;
    logic [63:0] hd;
    int w;
    w = $urandom_range(0, 99);
    act = (w < 3) ? 4'($urandom_range(9, 15)) :
          (w < 8) ? A_CLOSE_ALL : (w < 14) ? A_ASSIGN : 4'($urandom_range(0, 6));
    hd = pick_handle();
    pid = ($urandom_range(0, 9) == 0) ? 3'd0 :
          ($urandom_range(0, 2) != 0 && hd[63:32] == 0) ? hd[10:8] : 3'($urandom_range(1, 7));
    send(act, pid, 4'($urandom_range(0, 15)),
         ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom,
         ($urandom_range(0, 1)) ? 6'($urandom) :
           6'(($urandom_range(0, 1) ? R_READ : 0) | ($urandom_range(0, 1) ? R_QUERY : 0) |
              ($urandom_range(0, 1) ? R_SEND : 0)),
         hd, 3'($urandom), 6'($urandom_range(0, 7)), ($urandom_range(0, 5) != 0),
         ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'h3FF);
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed
    send(A_OPEN_SVC, 3'd0, 4'd0, 0, 0, 0, 0, 0, 0, 0);
    for (int s = 0; s < 10; s++) send(A_OPEN_SVC, 3'd1, 4'(s), 0, 0, 0, 0, 0, 0, 0);
    send(A_OPEN_FILE, 3'd2, 0, 32'd0, 0, 0, 0, 0, 0, 0);
    send(A_OPEN_FILE, 3'd2, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send(A_OPEN_IPC, 3'd2, 0, 32'd5, R_SEND | R_RECV, 0, 0, 0, 0, 0);
    send(A_OPEN_SURF, 3'd2, 0, 32'd77, R_READ | R_QUERY, 0, 0, 0, 1, 0);
    send(A_OPEN_SURF, 3'd2, 0, 32'd78, R_READ, 0, 0, 0, 0, 0);
    send(A_ASSIGN, 3'd3, 0, 0, 0, 0, 0, 0, 0, 10'h3FF);
    send(A_GRANT, 3'd2, 0, 0, R_READ, {32'd0, 16'd1, 8'd2, 8'd3}, 3'd3, 0, 1, 0);
    send(A_RESOLVE, 3'd2, 0, 0, 0, {32'd0, 16'd1, 8'd2, 8'd0}, 0, 6'h3F, 0, 0);
    send(A_RESOLVE, 3'd2, 0, 0, 0, {32'd0, 16'd1, 8'd2, 8'd0}, 0, R_READ, 0, 0);
    send(A_RESOLVE, 3'd2, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
    send(A_CLOSE, 3'd2, 0, 0, 0, {32'd0, 16'd1, 8'd2, 8'd3}, 0, 0, 0, 0);
    send(A_CLOSE_ALL, 3'd3, 0, 0, 0, 0, 0, 0, 0, 0);
    send(A_CLOSE_ALL, 3'd0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(4'd15, 3'd7, 4'd15, 0, 0, 0, 3'd7, 0, 0, 0);
    // many surfaces then close all: more opens than slots, close all fills every result
    send(A_ASSIGN, 3'd4, 0, 0, 0, 0, 0, 0, 0, 10'h3FF);
    for (int i = 0; i < 9; i++) send(A_OPEN_SURF, 3'd4, 0, 32'(100 + i), R_WRITE, 0, 0, 0, 1, 0);
    send(A_CLOSE_ALL, 3'd4, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 430; i++) begin
      if (i >= 370) quiet = 1;
      random_item();
    end
    req.valid <= 0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("generational_capability_table_core_tb passed");
    else
      $display("generational_capability_table_core_tb failed");
    $finish;
  end
endmodule

### generational_capability_table_core.f
hdl/gct_pkg.sv
hdl/gct_if.sv
hdl/gct_ram.sv
hdl/generational_capability_table_core.sv
tb/gct_tb_if.sv
tb/generational_capability_table_core_tb.sv
